// File: hw/rtl/lrbt_pkg.sv
// shared types, codes and constants for the lifo resource budget tracker
`default_nettype none

package lrbt_pkg;

   localparam int LIVE_DEPTH_DEF = 8;
   localparam int KIND_BITS_DEF  = 4;

   localparam int DATA_W    = 32;
   localparam int KIND_W    = 4;
   localparam int MODE_W    = 2;
   localparam int CODE_W    = 3;
   localparam int CSR_IDX_W = 2;

   localparam logic [DATA_W-1:0] MAX_OWNED_RST  = 32'd65536;
   localparam logic [DATA_W-1:0] MIN_HEAP_RST   = 32'd32768;
   localparam logic [DATA_W-1:0] MIN_BLOCK_RST  = 32'd16384;
   localparam logic [DATA_W-1:0] MIN_MARGIN_RST = 32'd1024;

   typedef enum logic [MODE_W-1:0] {
      MODE_START   = 2'd0,
      MODE_ACQUIRE = 2'd1,
      MODE_RELEASE = 2'd2,
      MODE_RUNTIME = 2'd3
   } mode_type;

   typedef enum logic [CODE_W-1:0] {
      EV_START_OK    = 3'd0,
      EV_START_REJ   = 3'd1,
      EV_ACQUIRED    = 3'd2,
      EV_RELEASED    = 3'd3,
      EV_ACCT_REJ    = 3'd4,
      EV_RUNTIME_REJ = 3'd5,
      EV_NONE        = 3'd6
   } event_code_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAX_OWNED  = 2'd0,
      CSR_MIN_HEAP   = 2'd1,
      CSR_MIN_BLOCK  = 2'd2,
      CSR_MIN_MARGIN = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_SCAN   = 2'd1,
      ST_REL    = 2'd2,
      ST_FINISH = 2'd3
   } state_type;

   typedef struct packed {
      logic cap;
      logic rd_scan;
      logic rd_top;
      logic fin;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
      logic live_zero;
   } status_type;

endpackage

`default_nettype wire

// File: hw/rtl/lrbt_ctrl.sv
// controller state machine: sequences capture, stack scan, top read and result load
`default_nettype none

module lrbt_ctrl (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   input  wire logic [lrbt_pkg::MODE_W-1:0]  req_mode,
   input  wire logic                         rsp_stall,
   input  wire lrbt_pkg::status_type         status,
   output lrbt_pkg::cmd_type                 cmd,
   output logic                              req_stall,
   output logic                              rsp_valid
);
   import lrbt_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.cap = 1'b1;
               case (mode_type'(req_mode))
                  MODE_ACQUIRE: state_in = ST_SCAN;
                  MODE_RELEASE: state_in = ST_REL;
                  default:      state_in = ST_FINISH;
               endcase
            end
         end
         ST_SCAN: begin
            if (status.scan_done) begin
               state_in = ST_FINISH;
            end else begin
               cmd.rd_scan = 1'b1;
            end
         end
         ST_REL: begin
            cmd.rd_top = !status.live_zero;
            state_in   = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.fin  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = cmd.fin | (rsp_valid_ff & rsp_stall);
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// File: hw/rtl/lrbt_dpath.sv
// datapath: config registers, grant stack memory, totals and result register
`default_nettype none

module lrbt_dpath #(
   parameter int LIVE_DEPTH = lrbt_pkg::LIVE_DEPTH_DEF,
   parameter int KIND_BITS  = lrbt_pkg::KIND_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire lrbt_pkg::cmd_type               cmd,
   output lrbt_pkg::status_type                 status,
   input  wire logic [lrbt_pkg::MODE_W-1:0]     req_mode,
   input  wire logic [lrbt_pkg::KIND_W-1:0]     req_res_kind,
   input  wire logic [lrbt_pkg::DATA_W-1:0]     req_req_bytes,
   input  wire logic [lrbt_pkg::DATA_W-1:0]     req_free_heap,
   input  wire logic [lrbt_pkg::DATA_W-1:0]     req_largest_block,
   input  wire logic [lrbt_pkg::DATA_W-1:0]     req_stack_margin,
   input  wire logic                            csr_valid,
   input  wire logic [lrbt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [lrbt_pkg::DATA_W-1:0]     csr_data,
   output logic                                 rsp_accepted,
   output logic [lrbt_pkg::CODE_W-1:0]          rsp_event_code,
   output logic [lrbt_pkg::KIND_W-1:0]          rsp_event_kind,
   output logic [lrbt_pkg::DATA_W-1:0]          rsp_event_bytes,
   output logic [lrbt_pkg::DATA_W-1:0]          rsp_total_bytes,
   output logic [lrbt_pkg::DATA_W-1:0]          rsp_peak_total
);
   import lrbt_pkg::*;

   localparam int CNT_W  = $clog2(LIVE_DEPTH + 1);
   localparam int ADDR_W = (LIVE_DEPTH > 1) ? $clog2(LIVE_DEPTH) : 1;
   localparam logic [KIND_W-1:0] KIND_MASK = KIND_W'((1 << KIND_BITS) - 1);

   // grant stack
   logic [KIND_BITS-1:0] kind_mem [LIVE_DEPTH];
   logic [DATA_W-1:0]    bytes_mem [LIVE_DEPTH];

   logic [DATA_W-1:0] max_owned_ff, min_heap_ff, min_block_ff, min_margin_ff;

   logic [CNT_W-1:0]  live_ff, live_in;
   logic [DATA_W-1:0] total_ff, total_in;
   logic [DATA_W-1:0] peak_ff, peak_in;
   logic [CNT_W-1:0]  scan_idx_ff, scan_idx_in;
   logic              dup_ff, dup_in;
   logic              rd_pend_ff;

   mode_type          mode_ff;
   logic [KIND_W-1:0] kind_ff;
   logic [DATA_W-1:0] req_ff, heap_ff, block_ff, margin_ff;

   logic [KIND_BITS-1:0] rd_kind_ff;
   logic [DATA_W-1:0]    rd_bytes_ff;

   logic                 rsp_accepted_ff, rsp_accepted_in;
   event_code_type       rsp_code_ff, rsp_code_in;
   logic [KIND_W-1:0]    rsp_kind_ff, rsp_kind_in;
   logic [DATA_W-1:0]    rsp_bytes_ff, rsp_bytes_in;
   logic [DATA_W-1:0]    rsp_total_ff;
   logic [DATA_W-1:0]    rsp_peak_ff;

   logic [KIND_BITS-1:0] kind_cmp;
   logic [CNT_W-1:0]     live_m1;
   logic [ADDR_W-1:0]    rd_addr;
   logic [ADDR_W-1:0]    wr_addr;
   logic                 wr_en;
   logic                 full;
   logic                 over;
   logic                 acq_ok;
   logic                 rel_ok;
   logic                 start_ok;
   logic                 run_ok;
   logic [DATA_W-1:0]    sum;

   assign kind_cmp = KIND_BITS'(kind_ff);
   assign live_m1  = live_ff - CNT_W'(1);
   assign rd_addr  = cmd.rd_top ? live_m1[ADDR_W-1:0] : scan_idx_ff[ADDR_W-1:0];
   assign wr_addr  = live_ff[ADDR_W-1:0];

   assign status.scan_done = (scan_idx_ff == live_ff);
   assign status.live_zero = (live_ff == '0);

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_owned_ff  <= MAX_OWNED_RST;
         min_heap_ff   <= MIN_HEAP_RST;
         min_block_ff  <= MIN_BLOCK_RST;
         min_margin_ff <= MIN_MARGIN_RST;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_MAX_OWNED:  max_owned_ff  <= csr_data;
            CSR_MIN_HEAP:   min_heap_ff   <= csr_data;
            CSR_MIN_BLOCK:  min_block_ff  <= csr_data;
            CSR_MIN_MARGIN: min_margin_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      full     = (live_ff == CNT_W'(LIVE_DEPTH));
      over     = (req_ff > max_owned_ff) || (total_ff > (max_owned_ff - req_ff));
      acq_ok   = !dup_ff && !full && !over;
      sum      = total_ff + req_ff;
      rel_ok   = (live_ff != '0) && (rd_kind_ff == kind_cmp);
      start_ok = (heap_ff >= min_heap_ff) && (block_ff >= min_block_ff);
      run_ok   = (total_ff <= max_owned_ff) && (margin_ff >= min_margin_ff);

      scan_idx_in = cmd.cap ? '0 : (cmd.rd_scan ? scan_idx_ff + CNT_W'(1) : scan_idx_ff);
      dup_in      = cmd.cap ? 1'b0 : (dup_ff | (rd_pend_ff && (rd_kind_ff == kind_cmp)));

      live_in         = live_ff;
      total_in        = total_ff;
      peak_in         = peak_ff;
      wr_en           = 1'b0;
      rsp_accepted_in = 1'b0;
      rsp_code_in     = EV_NONE;
      rsp_kind_in     = '0;
      rsp_bytes_in    = '0;
      case (mode_ff)
         MODE_START: begin
            rsp_accepted_in = start_ok;
            rsp_code_in     = start_ok ? EV_START_OK : EV_START_REJ;
         end
         MODE_ACQUIRE: begin
            rsp_kind_in  = kind_ff;
            rsp_bytes_in = req_ff;
            if (acq_ok) begin
               rsp_accepted_in = 1'b1;
               rsp_code_in     = EV_ACQUIRED;
               wr_en           = cmd.fin;
               live_in         = live_ff + CNT_W'(1);
               total_in        = sum;
               peak_in         = (sum > peak_ff) ? sum : peak_ff;
            end else begin
               rsp_code_in = EV_ACCT_REJ;
            end
         end
         MODE_RELEASE: begin
            rsp_kind_in = kind_ff;
            if (rel_ok) begin
               rsp_accepted_in = 1'b1;
               rsp_code_in     = EV_RELEASED;
               rsp_bytes_in    = rd_bytes_ff;
               live_in         = live_m1;
               total_in        = total_ff - rd_bytes_ff;
            end else begin
               rsp_code_in = EV_ACCT_REJ;
            end
         end
         MODE_RUNTIME: begin
            rsp_accepted_in = run_ok;
            rsp_code_in     = run_ok ? EV_NONE : EV_RUNTIME_REJ;
         end
         default: rsp_code_in = EV_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff     <= '0;
         total_ff    <= '0;
         peak_ff     <= '0;
         scan_idx_ff <= '0;
         dup_ff      <= 1'b0;
         rd_pend_ff  <= 1'b0;
      end else begin
         scan_idx_ff <= scan_idx_in;
         dup_ff      <= dup_in;
         rd_pend_ff  <= cmd.rd_scan;
         if (cmd.fin) begin
            live_ff  <= live_in;
            total_ff <= total_in;
            peak_ff  <= peak_in;
         end
      end
   end

   // captured request word
   always_ff @(posedge clock) begin
      if (cmd.cap) begin
         mode_ff   <= mode_type'(req_mode);
         kind_ff   <= req_res_kind & KIND_MASK;
         req_ff    <= req_req_bytes;
         heap_ff   <= req_free_heap;
         block_ff  <= req_largest_block;
         margin_ff <= req_stack_margin;
      end
   end

   // stack memory, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         kind_mem[wr_addr]  <= kind_cmp;
         bytes_mem[wr_addr] <= req_ff;
      end
      if (cmd.rd_scan || cmd.rd_top) begin
         rd_kind_ff  <= kind_mem[rd_addr];
         rd_bytes_ff <= bytes_mem[rd_addr];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.fin) begin
         rsp_accepted_ff <= rsp_accepted_in;
         rsp_code_ff     <= rsp_code_in;
         rsp_kind_ff     <= rsp_kind_in;
         rsp_bytes_ff    <= rsp_bytes_in;
         rsp_total_ff    <= total_in;
         rsp_peak_ff     <= peak_in;
      end
   end

   assign rsp_accepted    = rsp_accepted_ff;
   assign rsp_event_code  = rsp_code_ff;
   assign rsp_event_kind  = rsp_kind_ff;
   assign rsp_event_bytes = rsp_bytes_ff;
   assign rsp_total_bytes = rsp_total_ff;
   assign rsp_peak_total  = rsp_peak_ff;

endmodule

`default_nettype wire

// File: hw/rtl/lifo_resource_budget_tracker.sv
// accept to result valid: start and runtime checks go straight to finish, a release
// reads the stack top, an acquire scans the stack (one stack memory read per live entry)
// one word in flight; the next word is taken in the cycle after the result is loaded,
// while that result may still wait in the output register
// synchronous reset restores config defaults and clears count, total, peak and valid;
// stack memory contents are not cleared (no clearing pass, block ready right after reset)
`default_nettype none

module lifo_resource_budget_tracker #(
   parameter int LIVE_DEPTH = lrbt_pkg::LIVE_DEPTH_DEF,
   parameter int KIND_BITS  = lrbt_pkg::KIND_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [lrbt_pkg::MODE_W-1:0]     req_mode,
   input  wire logic [lrbt_pkg::KIND_W-1:0]     req_res_kind,
   input  wire logic [lrbt_pkg::DATA_W-1:0]     req_req_bytes,
   input  wire logic [lrbt_pkg::DATA_W-1:0]     req_free_heap,
   input  wire logic [lrbt_pkg::DATA_W-1:0]     req_largest_block,
   input  wire logic [lrbt_pkg::DATA_W-1:0]     req_stack_margin,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic                                 rsp_accepted,
   output logic [lrbt_pkg::CODE_W-1:0]          rsp_event_code,
   output logic [lrbt_pkg::KIND_W-1:0]          rsp_event_kind,
   output logic [lrbt_pkg::DATA_W-1:0]          rsp_event_bytes,
   output logic [lrbt_pkg::DATA_W-1:0]          rsp_total_bytes,
   output logic [lrbt_pkg::DATA_W-1:0]          rsp_peak_total,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [lrbt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [lrbt_pkg::DATA_W-1:0]     csr_data
);
   import lrbt_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   lrbt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid)
   );

   lrbt_dpath #(
      .LIVE_DEPTH (LIVE_DEPTH),
      .KIND_BITS  (KIND_BITS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_mode          (req_mode),
      .req_res_kind      (req_res_kind),
      .req_req_bytes     (req_req_bytes),
      .req_free_heap     (req_free_heap),
      .req_largest_block (req_largest_block),
      .req_stack_margin  (req_stack_margin),
      .csr_valid         (csr_valid),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .rsp_accepted      (rsp_accepted),
      .rsp_event_code    (rsp_event_code),
      .rsp_event_kind    (rsp_event_kind),
      .rsp_event_bytes   (rsp_event_bytes),
      .rsp_total_bytes   (rsp_total_bytes),
      .rsp_peak_total    (rsp_peak_total)
   );

endmodule

`default_nettype wire

// File: hw/rtl/lrbt_chk.sv
// port-level assertion checker and its bind to the tracker
`default_nettype none

module lrbt_chk (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_valid,
   input wire logic                            req_stall,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_stall,
   input wire logic                            rsp_accepted,
   input wire logic [lrbt_pkg::CODE_W-1:0]     rsp_event_code,
   input wire logic [lrbt_pkg::KIND_W-1:0]     rsp_event_kind,
   input wire logic [lrbt_pkg::DATA_W-1:0]     rsp_event_bytes,
   input wire logic [lrbt_pkg::DATA_W-1:0]     rsp_total_bytes,
   input wire logic [lrbt_pkg::DATA_W-1:0]     rsp_peak_total
);
   import lrbt_pkg::*;

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_event_code)
         && $stable(rsp_accepted) && $stable(rsp_event_kind)
         && $stable(rsp_total_bytes) && $stable(rsp_event_bytes)
         && $stable(rsp_peak_total))
      else $error("stalled result changed");

   // accepted flag agrees with event code
   a_acc_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_accepted == (rsp_event_code == EV_START_OK
         || rsp_event_code == EV_ACQUIRED || rsp_event_code == EV_RELEASED
         || rsp_event_code == EV_NONE))
      else $error("accepted flag disagrees with event code");

   // peak never below the running total
   a_peak: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_peak_total >= rsp_total_bytes)
      else $error("peak below total");

   // one word at a time: busy right after a word is taken
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second word taken while busy");

endmodule

bind lifo_resource_budget_tracker lrbt_chk u_lrbt_chk (.*);

`default_nettype wire

// File: sim/tb_top.sv
// testbench for lifo_resource_budget_tracker: directed word table, then random traffic
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import lrbt_pkg::*;

   localparam int HOLD_CYCLES = 300;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_WORDS = 220;

   typedef struct packed {
      logic                accepted;
      event_code_type      code;
      logic [KIND_W-1:0]   kind;
      logic [DATA_W-1:0]   bytes;
      logic [DATA_W-1:0]   total;
      logic [DATA_W-1:0]   peak;
   } budget_event_type;

   typedef struct {
      mode_type            mode;
      logic [KIND_W-1:0]   kind;
      logic [DATA_W-1:0]   bytes;
      logic [DATA_W-1:0]   heap;
      logic [DATA_W-1:0]   block;
      logic [DATA_W-1:0]   margin;
      bit                  typed;
      budget_event_type    want;
   } tracker_word_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [MODE_W-1:0]      req_mode;
   logic [KIND_W-1:0]      req_res_kind;
   logic [DATA_W-1:0]      req_req_bytes;
   logic [DATA_W-1:0]      req_free_heap;
   logic [DATA_W-1:0]      req_largest_block;
   logic [DATA_W-1:0]      req_stack_margin;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic                   rsp_accepted;
   logic [CODE_W-1:0]      rsp_event_code;
   logic [KIND_W-1:0]      rsp_event_kind;
   logic [DATA_W-1:0]      rsp_event_bytes;
   logic [DATA_W-1:0]      rsp_total_bytes;
   logic [DATA_W-1:0]      rsp_peak_total;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [DATA_W-1:0]      csr_data;

   // predictor state and register copies
   logic [KIND_W-1:0]      kind_stack [LIVE_DEPTH_DEF];
   logic [DATA_W-1:0]      bytes_stack [LIVE_DEPTH_DEF];
   int                     live_count;
   logic [DATA_W-1:0]      owned_sum;
   logic [DATA_W-1:0]      owned_max;
   logic [DATA_W-1:0]      budget_limit;
   logic [DATA_W-1:0]      heap_floor;
   logic [DATA_W-1:0]      block_floor;
   logic [DATA_W-1:0]      margin_floor;

   budget_event_type       pending_events [$];
   tracker_word_type       directed_words [$];
   budget_event_type       want_ev;
   int                     error_count = 0;
   int                     results_seen = 0;
   int                     cycle_count = 0;
   bit                     gaps_on = 1'b1;
   bit                     hold_asked = 1'b0;

   lifo_resource_budget_tracker dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_res_kind      (req_res_kind),
      .req_req_bytes     (req_req_bytes),
      .req_free_heap     (req_free_heap),
      .req_largest_block (req_largest_block),
      .req_stack_margin  (req_stack_margin),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_accepted      (rsp_accepted),
      .rsp_event_code    (rsp_event_code),
      .rsp_event_kind    (rsp_event_kind),
      .rsp_event_bytes   (rsp_event_bytes),
      .rsp_total_bytes   (rsp_total_bytes),
      .rsp_peak_total    (rsp_peak_total),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic report_mismatch(string field, logic [DATA_W-1:0] got,
                                  logic [DATA_W-1:0] want);
      $display("mismatch on %s at result %0d: got %0h, want %0h",
               field, results_seen, got, want);
      error_count++;
   endtask

   task automatic predict_event(input tracker_word_type w, output budget_event_type o);
      logic dup;
      logic [DATA_W-1:0] freed;
      o.accepted = 1'b0;
      o.code = EV_NONE;
      o.kind = '0;
      o.bytes = '0;
      case (w.mode)
         MODE_START: begin
            o.accepted = (w.heap >= heap_floor) && (w.block >= block_floor);
            o.code = o.accepted ? EV_START_OK : EV_START_REJ;
         end
         MODE_ACQUIRE: begin
            dup = 1'b0;
            for (int i = 0; i < live_count; i++)
               if (kind_stack[i] == w.kind) dup = 1'b1;
            o.kind = w.kind;
            o.bytes = w.bytes;
            if (dup || live_count >= LIVE_DEPTH_DEF || w.bytes > budget_limit ||
                owned_sum > budget_limit - w.bytes) begin
               o.code = EV_ACCT_REJ;
            end else begin
               kind_stack[live_count] = w.kind;
               bytes_stack[live_count] = w.bytes;
               live_count++;
               owned_sum = owned_sum + w.bytes;
               if (owned_sum > owned_max) owned_max = owned_sum;
               o.accepted = 1'b1;
               o.code = EV_ACQUIRED;
            end
         end
         MODE_RELEASE: begin
            o.kind = w.kind;
            if (live_count == 0 || kind_stack[live_count-1] != w.kind) begin
               o.code = EV_ACCT_REJ;
            end else begin
               freed = bytes_stack[live_count-1];
               live_count--;
               owned_sum = owned_sum - freed;
               o.accepted = 1'b1;
               o.code = EV_RELEASED;
               o.bytes = freed;
            end
         end
         default: begin
            o.accepted = (owned_sum <= budget_limit) && (w.margin >= margin_floor);
            o.code = o.accepted ? EV_NONE : EV_RUNTIME_REJ;
         end
      endcase
      o.total = owned_sum;
      o.peak = owned_max;
   endtask

   task automatic add_row(mode_type m, logic [KIND_W-1:0] k, logic [DATA_W-1:0] b,
                          logic [DATA_W-1:0] h, logic [DATA_W-1:0] blk,
                          logic [DATA_W-1:0] mg, bit typed, logic acc,
                          event_code_type c, logic [DATA_W-1:0] eb,
                          logic [DATA_W-1:0] tot, logic [DATA_W-1:0] pk);
      tracker_word_type w;
      w.mode = m;
      w.kind = k;
      w.bytes = b;
      w.heap = h;
      w.block = blk;
      w.margin = mg;
      w.typed = typed;
      w.want.accepted = acc;
      w.want.code = c;
      w.want.kind = (m == MODE_START || m == MODE_RUNTIME) ? '0 : k;
      w.want.bytes = eb;
      w.want.total = tot;
      w.want.peak = pk;
      directed_words.push_back(w);
   endtask

   function automatic logic [DATA_W-1:0] around(logic [DATA_W-1:0] t);
      case ($urandom_range(0, 3))
         0: return t - 1;
         1: return t;
         2: return t + 1;
         default: return $urandom;
      endcase
   endfunction

   task automatic make_random_word(output tracker_word_type w);
      int pick;
      bit dup;
      logic [KIND_W-1:0] k;
      logic [DATA_W-1:0] room;
      pick = $urandom_range(0, 99);
      w.mode = mode_type'($urandom_range(0, 3));
      w.kind = KIND_W'($urandom);
      w.bytes = $urandom;
      w.heap = $urandom;
      w.block = $urandom;
      w.margin = $urandom;
      w.typed = 1'b0;
      w.want = '0;
      if (pick < 45) begin
         w.mode = MODE_ACQUIRE;
         if (pick < 40 && live_count < LIVE_DEPTH_DEF) begin
            dup = 1'b1;
            k = '0;
            while (dup) begin
               k = KIND_W'($urandom);
               dup = 1'b0;
               for (int i = 0; i < live_count; i++)
                  if (kind_stack[i] == k) dup = 1'b1;
            end
            w.kind = k;
            room = (owned_sum <= budget_limit) ? budget_limit - owned_sum : '0;
            case ($urandom_range(0, 3))
               0: w.bytes = $urandom_range(0, room >> 2);
               1: w.bytes = room;
               2: w.bytes = room + 1;
               default: w.bytes = $urandom_range(0, 255);
            endcase
         end
      end else if (pick < 81) begin
         w.mode = MODE_RELEASE;
         if (pick < 77 && live_count > 0) w.kind = kind_stack[live_count-1];
      end else if (pick < 91) begin
         w.mode = MODE_START;
         w.heap = around(heap_floor);
         w.block = around(block_floor);
      end else if (pick < 98) begin
         w.mode = MODE_RUNTIME;
         w.margin = around(margin_floor);
      end
   endtask

   // entered and left at a rising edge; valid stays high for a following word
   task automatic send_word(input tracker_word_type w);
      budget_event_type o;
      if (gaps_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= w.mode;
      req_res_kind <= w.kind;
      req_req_bytes <= w.bytes;
      req_free_heap <= w.heap;
      req_largest_block <= w.block;
      req_stack_margin <= w.margin;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_event(w, o);
      pending_events.push_back(w.typed ? w.want : o);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
   endtask

   task automatic program_regs(logic [0:3][DATA_W-1:0] regs);
      for (int i = 0; i < 4; i++) begin
         csr_valid <= 1'b1;
         csr_index <= csr_index_type'(i);
         csr_data <= regs[i];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         case (csr_index_type'(i))
            CSR_MAX_OWNED: budget_limit = regs[i];
            CSR_MIN_HEAP: heap_floor = regs[i];
            CSR_MIN_BLOCK: block_floor = regs[i];
            default: margin_floor = regs[i];
         endcase
      end
      csr_valid <= 1'b0;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_events.size() == 0) begin
            report_mismatch("word with nothing pending", DATA_W'(rsp_event_code), '0);
         end else begin
            want_ev = pending_events.pop_front();
            if (rsp_accepted !== want_ev.accepted)
               report_mismatch("accepted", DATA_W'(rsp_accepted),
                               DATA_W'(want_ev.accepted));
            if (rsp_event_code !== want_ev.code)
               report_mismatch("event_code", DATA_W'(rsp_event_code),
                               DATA_W'(want_ev.code));
            if (rsp_event_kind !== want_ev.kind)
               report_mismatch("event_kind", DATA_W'(rsp_event_kind),
                               DATA_W'(want_ev.kind));
            if (rsp_event_bytes !== want_ev.bytes)
               report_mismatch("event_bytes", rsp_event_bytes, want_ev.bytes);
            if (rsp_total_bytes !== want_ev.total)
               report_mismatch("total_bytes", rsp_total_bytes, want_ev.total);
            if (rsp_peak_total !== want_ev.peak)
               report_mismatch("peak_total", rsp_peak_total, want_ev.peak);
         end
         results_seen++;
      end
   end

   initial begin : rsp_side
      int span;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_asked) begin
            hold_asked = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (gaps_on && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            span = $urandom_range(1, 10);
            repeat (span) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if ($urandom_range(0, 15) == 0) begin
            span = $urandom_range(20, 60);
            repeat (span) @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      tracker_word_type w;
      logic [0:3][DATA_W-1:0] regs;
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_mode = MODE_START;
      req_res_kind = '0;
      req_req_bytes = '0;
      req_free_heap = '0;
      req_largest_block = '0;
      req_stack_margin = '0;
      csr_valid = 1'b0;
      csr_index = CSR_MAX_OWNED;
      csr_data = '0;
      live_count = 0;
      owned_sum = '0;
      owned_max = '0;
      budget_limit = MAX_OWNED_RST;
      heap_floor = MIN_HEAP_RST;
      block_floor = MIN_BLOCK_RST;
      margin_floor = MIN_MARGIN_RST;

      // start checks at and around the reset minimums
      add_row(MODE_START, 4'd9, 32'd123, 32'd32768, 32'd16384, 32'd0,
              1'b1, 1'b1, EV_START_OK, 32'd0, 32'd0, 32'd0);
      add_row(MODE_START, 4'd0, 32'd0, 32'd32767, 32'd16384, 32'd0,
              1'b1, 1'b0, EV_START_REJ, 32'd0, 32'd0, 32'd0);
      add_row(MODE_START, 4'd0, 32'd0, 32'd32768, 32'd16383, 32'd0,
              1'b1, 1'b0, EV_START_REJ, 32'd0, 32'd0, 32'd0);
      add_row(MODE_START, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0,
              1'b1, 1'b1, EV_START_OK, 32'd0, 32'd0, 32'd0);
      add_row(MODE_START, 4'd0, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF,
              1'b1, 1'b0, EV_START_REJ, 32'd0, 32'd0, 32'd0);
      // release on an empty stack
      add_row(MODE_RELEASE, 4'd5, 32'd77, 32'd0, 32'd0, 32'd0,
              1'b1, 1'b0, EV_ACCT_REJ, 32'd0, 32'd0, 32'd0);
      add_row(MODE_RUNTIME, 4'd0, 32'd0, 32'd0, 32'd0, 32'd1024,
              1'b1, 1'b1, EV_NONE, 32'd0, 32'd0, 32'd0);
      add_row(MODE_RUNTIME, 4'd3, 32'd5, 32'd0, 32'd0, 32'd1023,
              1'b1, 1'b0, EV_RUNTIME_REJ, 32'd0, 32'd0, 32'd0);
      add_row(MODE_RUNTIME, 4'd0, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF,
              1'b1, 1'b1, EV_NONE, 32'd0, 32'd0, 32'd0);
      // over budget, exact fit, one byte over, duplicate kind
      add_row(MODE_ACQUIRE, 4'd0, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0,
              1'b1, 1'b0, EV_ACCT_REJ, 32'hFFFF_FFFF, 32'd0, 32'd0);
      add_row(MODE_ACQUIRE, 4'd15, 32'd65536, 32'd0, 32'd0, 32'd0,
              1'b1, 1'b1, EV_ACQUIRED, 32'd65536, 32'd65536, 32'd65536);
      add_row(MODE_ACQUIRE, 4'd1, 32'd1, 32'd0, 32'd0, 32'd0,
              1'b1, 1'b0, EV_ACCT_REJ, 32'd1, 32'd65536, 32'd65536);
      add_row(MODE_ACQUIRE, 4'd15, 32'd0, 32'd0, 32'd0, 32'd0,
              1'b1, 1'b0, EV_ACCT_REJ, 32'd0, 32'd65536, 32'd65536);
      add_row(MODE_RUNTIME, 4'd0, 32'd0, 32'd0, 32'd0, 32'd0,
              1'b1, 1'b0, EV_RUNTIME_REJ, 32'd0, 32'd65536, 32'd65536);
      // release with the wrong kind, then the top kind
      add_row(MODE_RELEASE, 4'd3, 32'd0, 32'd0, 32'd0, 32'd0,
              1'b1, 1'b0, EV_ACCT_REJ, 32'd0, 32'd65536, 32'd65536);
      add_row(MODE_RELEASE, 4'd15, 32'd0, 32'd0, 32'd0, 32'd0,
              1'b1, 1'b1, EV_RELEASED, 32'd65536, 32'd0, 32'd65536);
      // fill the stack, then one more
      for (int k = 0; k <= LIVE_DEPTH_DEF; k++)
         add_row(MODE_ACQUIRE, KIND_W'(k), DATA_W'(100 * (k + 1)), 32'd0, 32'd0, 32'd0,
                 1'b0, 1'b0, EV_NONE, 32'd0, 32'd0, 32'd0);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_words[i]) send_word(directed_words[i]);

      for (int phase = 0; phase < 7; phase++) begin
         if (phase > 0) begin
            case (phase)
               1: regs = {32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0};
               2: regs = {32'd1000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
               3: regs = {32'd0, 32'd32768, 32'd16384, 32'd1024};
               4: regs = {MAX_OWNED_RST, MIN_HEAP_RST, MIN_BLOCK_RST, MIN_MARGIN_RST};
               5: regs = {32'($urandom), 32'($urandom), 32'($urandom), 32'($urandom)};
               default: regs = {32'd200000, 32'($urandom), 32'($urandom),
                                32'($urandom_range(0, 4096))};
            endcase
            settle();
            program_regs(regs);
         end
         gaps_on = (phase != 6);
         for (int n = 0; n < PHASE_WORDS; n++) begin
            // long output hold-off while words keep coming
            if (phase == 1 && n == 40) hold_asked = 1'b1;
            if (phase == 3 && n == 100) settle();
            make_random_word(w);
            send_word(w);
         end
      end

      settle();
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

`default_nettype wire
